### rtl/ir_beam_sync_break_detector_macros.svh
// Assertion macros for the IR beam sync and break detector.
// Included by the modules that carry assertions; expects clk and rst_n in scope.
`ifndef IR_BEAM_SYNC_BREAK_DETECTOR_MACROS_SVH
`define IR_BEAM_SYNC_BREAK_DETECTOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// property checked only out of reset
`define IBSB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property checked in every cycle, reset included
`define IBSB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IBSB_ASSERT(lbl, prop, msg)
`define IBSB_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/ibsb_pkg.sv
// Shared types and constants for the IR beam sync and break detector.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ibsb_pkg;

  // field widths
  localparam int STAMP_BITS_DEF = 24;
  localparam int TOL_BITS       = 7;
  localparam int TIMEOUT_BITS   = 26;
  localparam int SHOTS_BITS     = 2;
  localparam int FTIME_BITS     = 27;
  localparam int INTERVAL_BITS  = 24;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 26;
  localparam int K_BITS         = 8;

  // percent reference for the tolerance compare
  localparam logic [K_BITS-1:0] PERCENT = 8'd100;

  // register reset values
  localparam logic [TOL_BITS-1:0]     TOL_RESET     = 7'd10;
  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 26'd19660800;
  localparam logic [SHOTS_BITS-1:0]   SHOTS_RESET   = 2'd0;
  localparam logic [SHOTS_BITS-1:0]   SHOTS_MAX     = 2'd2;

  // pulses collected before the lock check
  localparam logic [1:0] PULSES_FOR_SYNC = 2'd3;

  // register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TOLERANCE = 2'd0,
    REG_TIMEOUT   = 2'd1,
    REG_SHOTS     = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_t;

  // event kinds
  typedef enum logic [1:0] {
    FUNC_PULSE = 2'd0,
    FUNC_MISS  = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_START = 2'd3
  } func_t;

  // receiver modes
  typedef enum logic {
    MODE_SYNC  = 1'b0,
    MODE_WATCH = 1'b1
  } mode_t;

  // configuration registers
  typedef struct packed {
    logic [TOL_BITS-1:0]     tolerance_percent;
    logic [TIMEOUT_BITS-1:0] feedback_timeout;
    logic [SHOTS_BITS-1:0]   shot_setting;
  } cfg_t;

  // one result word
  typedef struct packed {
    logic                  mode_now;
    logic                  sync_locked;
    logic                  sync_entered;
    logic                  camera_trigger;
    logic [SHOTS_BITS-1:0] trigger_shots;
    logic                  feedback_start;
    logic                  feedback_stop;
    logic                  pulse_rearm;
  } res_t;

endpackage

### rtl/ibsb_tol_check.sv
// Gap tolerance compare: second gap within +/- percent of the first gap.
// Depends on ibsb_pkg.
`timescale 1ns / 1ps

module ibsb_tol_check
  import ibsb_pkg::*;
#(
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic [STAMP_BITS-1:0] first_gap,
  input  logic [STAMP_BITS-1:0] second_gap,
  input  logic [TOL_BITS-1:0]   tolerance,
  output logic                  gap_ok
);

  localparam int PW = STAMP_BITS + K_BITS;

  logic [K_BITS-1:0] upper_k;
  logic [K_BITS-1:0] lower_k;
  logic [PW-1:0]     scaled;
  logic [PW-1:0]     upper;
  logic [PW-1:0]     lower;
  logic              wide_tol;

  // scale factors 100+tol and 100-tol
  assign upper_k  = PERCENT + K_BITS'(tolerance);
  assign lower_k  = PERCENT - K_BITS'(tolerance);
  assign wide_tol = (K_BITS'(tolerance) >= PERCENT);

  // three narrow products in parallel
  assign scaled = PW'(second_gap) * PW'(PERCENT);
  assign upper  = PW'(first_gap) * PW'(upper_k);
  assign lower  = PW'(first_gap) * PW'(lower_k);

  // lower bound drops out at 100 percent and above
  assign gap_ok = (scaled <= upper) && (wide_tol || (scaled >= lower));

endmodule

### rtl/ibsb_ctrl.sv
// Receiver state and per-word event decode: sync gap collection, mode,
// feedback timer. Depends on ibsb_pkg, ibsb_tol_check and the macro header.
`timescale 1ns / 1ps
`include "ir_beam_sync_break_detector_macros.svh"

module ibsb_ctrl
  import ibsb_pkg::*;
#(
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     advance,
  input  func_t                    func,
  input  logic [STAMP_BITS-1:0]    stamp,
  input  logic [INTERVAL_BITS-1:0] interval,
  input  cfg_t                     cfg,
  output res_t                     res
);

  // pulses_left values for each sync step
  localparam logic [1:0] PL_FIRST_GAP  = 2'd2;
  localparam logic [1:0] PL_SECOND_GAP = 2'd1;
  localparam logic [1:0] PL_CHECK      = 2'd0;

  mode_t                  mode_r, mode_nxt;
  logic [1:0]             pulses_left_r, pulses_left_nxt;
  logic [STAMP_BITS-1:0]  prev_stamp_r, prev_stamp_nxt;
  logic [STAMP_BITS-1:0]  first_gap_r, first_gap_nxt;
  logic [STAMP_BITS-1:0]  second_gap_r, second_gap_nxt;
  logic [FTIME_BITS-1:0]  ftime_r, ftime_nxt;

  logic [STAMP_BITS-1:0]  gap;
  logic [FTIME_BITS-1:0]  ftime_sum;
  logic [FTIME_BITS-1:0]  timeout_ext;
  logic                   gaps_match;

  assign gap         = stamp - prev_stamp_r;
  assign ftime_sum   = ftime_r + FTIME_BITS'(interval);
  assign timeout_ext = FTIME_BITS'(cfg.feedback_timeout);

  ibsb_tol_check #(
    .STAMP_BITS (STAMP_BITS)
  ) u_tol_check (
    .first_gap  (first_gap_r),
    .second_gap (second_gap_r),
    .tolerance  (cfg.tolerance_percent),
    .gap_ok     (gaps_match)
  );

  // event decode and next state
  always_comb begin
    mode_nxt        = mode_r;
    pulses_left_nxt = pulses_left_r;
    prev_stamp_nxt  = prev_stamp_r;
    first_gap_nxt   = first_gap_r;
    second_gap_nxt  = second_gap_r;
    ftime_nxt       = ftime_r;
    res             = '0;
    unique case (func)
      FUNC_PULSE: begin
        if (mode_r == MODE_SYNC) begin
          priority if (pulses_left_r == PULSES_FOR_SYNC) begin
            prev_stamp_nxt  = stamp;
            pulses_left_nxt = PL_FIRST_GAP;
          end else if (pulses_left_r == PL_FIRST_GAP) begin
            first_gap_nxt   = gap;
            prev_stamp_nxt  = stamp;
            pulses_left_nxt = PL_SECOND_GAP;
          end else if (pulses_left_r == PL_SECOND_GAP) begin
            second_gap_nxt  = gap;
            prev_stamp_nxt  = stamp;
            pulses_left_nxt = PL_CHECK;
          end else begin
            pulses_left_nxt = PULSES_FOR_SYNC;
          end
          if ((pulses_left_r == PL_CHECK) && gaps_match) begin
            res.sync_locked = 1'b1;
            mode_nxt        = MODE_WATCH;
          end else begin
            res.pulse_rearm   = 1'b1;
            res.feedback_stop = 1'b1;
          end
        end else begin
          res.feedback_start = (ftime_r < timeout_ext);
        end
      end
      FUNC_MISS: begin
        res.feedback_stop  = 1'b1;
        res.sync_entered   = 1'b1;
        res.camera_trigger = 1'b1;
        res.trigger_shots  = cfg.shot_setting;
        mode_nxt           = MODE_SYNC;
      end
      FUNC_TICK: begin
        if (ftime_sum >= timeout_ext) begin
          res.feedback_stop = 1'b1;
          ftime_nxt         = '0;
        end else begin
          ftime_nxt = ftime_sum;
        end
      end
      FUNC_START: begin
        ftime_nxt        = '0;
        res.sync_entered = 1'b1;
        mode_nxt         = MODE_SYNC;
      end
    endcase
    res.mode_now = mode_nxt;
  end

  // state registers, updated as each word moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_WATCH;
      pulses_left_r <= PULSES_FOR_SYNC;
      prev_stamp_r  <= '0;
      first_gap_r   <= '0;
      second_gap_r  <= '0;
      ftime_r       <= '0;
    end else if (advance) begin
      mode_r        <= mode_nxt;
      pulses_left_r <= pulses_left_nxt;
      prev_stamp_r  <= prev_stamp_nxt;
      first_gap_r   <= first_gap_nxt;
      second_gap_r  <= second_gap_nxt;
      ftime_r       <= ftime_nxt;
    end
  end

  // reset leaves the receiver watching with a full pulse count
  `IBSB_ASSERT_ALWAYS(a_reset_state, !rst_n |=> (mode_r == MODE_WATCH) && (pulses_left_r == PULSES_FOR_SYNC), "reset state wrong")
  // a lock restarts the pulse count and enters watching
  `IBSB_ASSERT(a_lock_rearms, advance && res.sync_locked |=> (mode_r == MODE_WATCH) && (pulses_left_r == PULSES_FOR_SYNC), "lock did not restart sync")
  // a tick timeout clears the feedback timer
  `IBSB_ASSERT(a_tick_clear, advance && (func == FUNC_TICK) && res.feedback_stop |=> ftime_r == '0, "feedback timer not cleared")

endmodule

### rtl/ir_beam_sync_break_detector.sv
// Top level of the IR beam sync and break detector: configuration registers,
// input register, result register. Depends on ibsb_pkg, ibsb_ctrl, macro header.
`timescale 1ns / 1ps
`include "ir_beam_sync_break_detector_macros.svh"

// IR beam receiver controller. Each accepted event word (pulse, window missed,
// tick, start) gives exactly one result word. It takes one word per clock while
// the result side does not stall; an accepted word is loaded into the input
// register and moves on into the result register once that register is free or
// being drained, with the sync gap check and feedback timer update done in the
// single logic stage between them. The input side keeps taking words while a
// result waits, as long as the input register is empty or drains into the result
// register. Configuration (tolerance percent, feedback timeout, shot setting) is
// written through cfg_wr_en, cfg_index and cfg_wdata with no wait; a shot setting
// of 3 is held as 2 and index 3 is ignored. After reset the receiver is in
// watching mode.
module ir_beam_sync_break_detector
  import ibsb_pkg::*;
#(
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration write port
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  // event channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_func,
  input  logic [STAMP_BITS-1:0]    in_pulse_stamp,
  input  logic [INTERVAL_BITS-1:0] in_tick_interval,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_mode_now,
  output logic                     out_sync_locked,
  output logic                     out_sync_entered,
  output logic                     out_camera_trigger,
  output logic [SHOTS_BITS-1:0]    out_trigger_shots,
  output logic                     out_feedback_start,
  output logic                     out_feedback_stop,
  output logic                     out_pulse_rearm
);

  cfg_t                     cfg_r;
  logic [SHOTS_BITS-1:0]    shots_wr;

  logic                     in_valid_r;
  func_t                    func_r;
  logic [STAMP_BITS-1:0]    stamp_r;
  logic [INTERVAL_BITS-1:0] interval_r;

  logic                     out_valid_r;
  res_t                     res_r;
  res_t                     res_nxt;
  logic                     advance;

  // configuration registers, shot setting saturated at two shots
  assign shots_wr = (cfg_wdata[SHOTS_BITS-1:0] > SHOTS_MAX) ? SHOTS_MAX
                                                            : cfg_wdata[SHOTS_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tolerance_percent <= TOL_RESET;
      cfg_r.feedback_timeout  <= TIMEOUT_RESET;
      cfg_r.shot_setting      <= SHOTS_RESET;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TOLERANCE: cfg_r.tolerance_percent <= cfg_wdata[TOL_BITS-1:0];
        REG_TIMEOUT:   cfg_r.feedback_timeout  <= cfg_wdata[TIMEOUT_BITS-1:0];
        REG_SHOTS:     cfg_r.shot_setting      <= shots_wr;
        REG_NONE:      cfg_r                   <= cfg_r;
      endcase
    end
  end

  // word moves on when the result register is free or being drained
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_r     <= func_t'(in_func);
      stamp_r    <= in_pulse_stamp;
      interval_r <= in_tick_interval;
    end
  end

  ibsb_ctrl #(
    .STAMP_BITS (STAMP_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .func     (func_r),
    .stamp    (stamp_r),
    .interval (interval_r),
    .cfg      (cfg_r),
    .res      (res_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_mode_now       = res_r.mode_now;
  assign out_sync_locked    = res_r.sync_locked;
  assign out_sync_entered   = res_r.sync_entered;
  assign out_camera_trigger = res_r.camera_trigger;
  assign out_trigger_shots  = res_r.trigger_shots;
  assign out_feedback_start = res_r.feedback_start;
  assign out_feedback_stop  = res_r.feedback_stop;
  assign out_pulse_rearm    = res_r.pulse_rearm;

  // an empty result register never blocks the input
  `IBSB_ASSERT(a_ready_when_empty, !out_valid_r |-> in_ready, "input blocked with empty output")
  // a held word reaches the result register when the output is free
  `IBSB_ASSERT(a_word_moves, in_valid_r && !out_valid_r |=> out_valid_r, "held word did not move")
  // a camera trigger always comes with entry to syncing
  `IBSB_ASSERT(a_trigger_syncs, out_valid_r && res_r.camera_trigger |-> res_r.sync_entered && !res_r.mode_now, "trigger without sync entry")

endmodule

### tb/testbench.sv
// Testbench for ir_beam_sync_break_detector: directed and random event words,
// checked against an in-bench predictor of the sync, break and feedback logic.
// Depends on ibsb_pkg and the ir_beam_sync_break_detector RTL.
`timescale 1ns / 1ps

module testbench;
  import ibsb_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_wr_en;
  reg_idx_t                 cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;
  logic                     in_valid;
  logic                     in_ready;
  func_t                    in_func;
  logic [23:0]              in_pulse_stamp;
  logic [INTERVAL_BITS-1:0] in_tick_interval;
  logic                     out_valid;
  logic                     out_ready;
  logic                     out_mode_now;
  logic                     out_sync_locked;
  logic                     out_sync_entered;
  logic                     out_camera_trigger;
  logic [SHOTS_BITS-1:0]    out_trigger_shots;
  logic                     out_feedback_start;
  logic                     out_feedback_stop;
  logic                     out_pulse_rearm;

  // predictor state and register copies
  mode_t                    st_mode;
  logic [1:0]               st_pulses_left;
  logic [23:0]              st_prev_stamp;
  logic [23:0]              st_gap0;
  logic [23:0]              st_gap1;
  logic [FTIME_BITS-1:0]    st_fb_time;
  logic [TOL_BITS-1:0]      cf_tol;
  logic [TIMEOUT_BITS-1:0]  cf_timeout;
  logic [SHOTS_BITS-1:0]    cf_shots;

  res_t expected_results[$];
  int   n_errors;
  int   words_sent;
  int   quiet_cycles;
  int   sink_hold_req;
  bit   tx_idling;
  bit   rx_idling;

  ir_beam_sync_break_detector dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_pulse_stamp     (in_pulse_stamp),
    .in_tick_interval   (in_tick_interval),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_mode_now       (out_mode_now),
    .out_sync_locked    (out_sync_locked),
    .out_sync_entered   (out_sync_entered),
    .out_camera_trigger (out_camera_trigger),
    .out_trigger_shots  (out_trigger_shots),
    .out_feedback_start (out_feedback_start),
    .out_feedback_stop  (out_feedback_stop),
    .out_pulse_rearm    (out_pulse_rearm)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // idle length: mostly short, a few long
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // tick interval: full range, small, or a fraction of the timeout
  function automatic logic [23:0] tick_span();
    case ($urandom_range(0, 2))
      0: return 24'($urandom());
      1: return 24'($urandom_range(0, 255));
      default: return 24'(cf_timeout >> $urandom_range(1, 3));
    endcase
  endfunction

  // expected result of one event word; advances the predictor state
  function automatic res_t beam_event_result(func_t f, logic [23:0] stamp,
                                             logic [23:0] ivl);
    res_t        r;
    logic [23:0] gap;
    logic [39:0] scaled;
    logic [39:0] upper;
    logic [39:0] lower;
    logic        locked;
    r = '0;
    case (f)
      FUNC_PULSE: begin
        if (st_mode == MODE_SYNC) begin
          locked = 1'b0;
          if (st_pulses_left == PULSES_FOR_SYNC) begin
            st_prev_stamp  = stamp;
            st_pulses_left = st_pulses_left - 2'd1;
          end else if (st_pulses_left != 2'd0) begin
            gap = stamp - st_prev_stamp;
            if (st_pulses_left == 2'd2) st_gap0 = gap;
            else st_gap1 = gap;
            st_prev_stamp  = stamp;
            st_pulses_left = st_pulses_left - 2'd1;
          end else begin
            // fourth pulse: compare second gap against first, stamp unused
            st_pulses_left = PULSES_FOR_SYNC;
            scaled = 40'(st_gap1) * 40'(PERCENT);
            upper  = 40'(st_gap0) * (40'(PERCENT) + 40'(cf_tol));
            lower  = (cf_tol >= TOL_BITS'(PERCENT)) ? 40'd0 :
                     40'(st_gap0) * (40'(PERCENT) - 40'(cf_tol));
            locked = (scaled <= upper) && (scaled >= lower);
          end
          if (locked) begin
            r.sync_locked = 1'b1;
            st_mode       = MODE_WATCH;
          end else begin
            r.pulse_rearm   = 1'b1;
            r.feedback_stop = 1'b1;
          end
        end else if (st_fb_time < FTIME_BITS'(cf_timeout)) begin
          r.feedback_start = 1'b1;
        end
      end
      FUNC_MISS: begin
        r.feedback_stop  = 1'b1;
        r.sync_entered   = 1'b1;
        r.camera_trigger = 1'b1;
        r.trigger_shots  = cf_shots;
        st_mode          = MODE_SYNC;
      end
      FUNC_TICK: begin
        st_fb_time = st_fb_time + FTIME_BITS'(ivl);
        if (st_fb_time >= FTIME_BITS'(cf_timeout)) begin
          r.feedback_stop = 1'b1;
          st_fb_time      = '0;
        end
      end
      default: begin
        st_fb_time     = '0;
        st_mode        = MODE_SYNC;
        r.sync_entered = 1'b1;
      end
    endcase
    r.mode_now = st_mode;
    return r;
  endfunction

  // offer one word, wait for acceptance, then maybe idle
  task automatic send_word(func_t f, logic [23:0] stamp, logic [23:0] ivl);
    int gap;
    in_valid         <= 1'b1;
    in_func          <= f;
    in_pulse_stamp   <= stamp;
    in_tick_interval <= ivl;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(beam_event_result(f, stamp, ivl));
    words_sent++;
    gap = tx_idling ? pause_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering and wait until every expected word has come back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // register write, only called while the block is idle
  task automatic cfg_write(reg_idx_t idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_TOLERANCE: cf_tol = data[TOL_BITS-1:0];
      REG_TIMEOUT:   cf_timeout = data[TIMEOUT_BITS-1:0];
      REG_SHOTS:     cf_shots = (data[1:0] > SHOTS_MAX) ? SHOTS_MAX : data[1:0];
      default: ;
    endcase
  endtask

  // reset registers: feedback, timeout, break, lock and a failed lock
  task automatic test_power_on_state();
    send_word(FUNC_PULSE, 24'h000000, 24'h000000);
    send_word(FUNC_TICK,  24'h000000, 24'hFFFFFF);
    send_word(FUNC_PULSE, 24'hFFFFFF, 24'h000000);
    send_word(FUNC_TICK,  24'h000000, 24'hFFFFFF);
    send_word(FUNC_MISS,  24'h000000, 24'h000000);
    // gaps across the stamp wrap
    send_word(FUNC_PULSE, 24'hFFFFF0, 24'h000000);
    send_word(FUNC_PULSE, 24'h000010, 24'h000000);
    send_word(FUNC_PULSE, 24'h000030, 24'h000000);
    send_word(FUNC_PULSE, 24'h123456, 24'h000000);
    send_word(FUNC_START, 24'h000000, 24'h000000);
    // second gap just over ten percent
    send_word(FUNC_PULSE, 24'd0,   24'h000000);
    send_word(FUNC_PULSE, 24'd100, 24'h000000);
    send_word(FUNC_PULSE, 24'd211, 24'h000000);
    send_word(FUNC_PULSE, 24'd0,   24'h000000);
  endtask

  // zero tolerance, saturated shots, zero timeout, unused index, wide tolerance
  task automatic test_register_extremes();
    wait_results_drained();
    cfg_write(REG_TOLERANCE, {19'h7FFFF, 7'd0});
    cfg_write(REG_SHOTS, 26'd3);
    cfg_write(REG_TIMEOUT, 26'd0);
    cfg_write(REG_NONE, 26'h3FFFFFF);
    send_word(FUNC_PULSE, 24'd5,    24'h000000);
    send_word(FUNC_PULSE, 24'd1005, 24'h000000);
    send_word(FUNC_PULSE, 24'd2005, 24'h000000);
    send_word(FUNC_PULSE, 24'd7,    24'h000000);
    send_word(FUNC_PULSE, 24'd9,    24'h000000);
    send_word(FUNC_MISS,  24'd0,    24'h000000);
    send_word(FUNC_TICK,  24'd0,    24'h000000);
    wait_results_drained();
    // tolerance above 100: any shorter second gap locks
    cfg_write(REG_TOLERANCE, 26'h7F);
    send_word(FUNC_PULSE, 24'd0,    24'h000000);
    send_word(FUNC_PULSE, 24'd1000, 24'h000000);
    send_word(FUNC_PULSE, 24'd1000, 24'h000000);
    send_word(FUNC_PULSE, 24'd0,    24'h000000);
  endtask

  // result side held off while words keep coming
  task automatic test_result_backpressure();
    wait_results_drained();
    tx_idling     = 1'b0;
    sink_hold_req = HOLD_CYCLES;
    repeat (40) send_word(func_t'($urandom_range(0, 3)), 24'($urandom()), tick_span());
    tx_idling = 1'b1;
    wait_results_drained();
  endtask

  // random traffic under several register settings
  task automatic test_random_traffic();
    logic [TOL_BITS-1:0]     tol;
    logic [TIMEOUT_BITS-1:0] timeout_val;
    logic [1:0]              shots;
    logic [23:0]             g0;
    logic [23:0]             g1;
    logic [23:0]             base;
    int                      span;
    int                      pct;
    int                      pick;
    int                      target;
    for (int ph = 0; ph < 8; ph++) begin
      wait_results_drained();
      case (ph)
        0: begin tol = 7'd10;  timeout_val = TIMEOUT_RESET; shots = 2'd1; end
        1: begin tol = 7'd0;   timeout_val = 26'd0;         shots = 2'd2; end
        2: begin tol = 7'd100; timeout_val = 26'h3FFFFFF;   shots = 2'd3; end
        3: begin tol = 7'd127; timeout_val = 26'($urandom_range(1, 5000)); shots = 2'd0; end
        default: begin
          tol         = 7'($urandom_range(0, 127));
          timeout_val = $urandom_range(0, 1) ? 26'($urandom()) : 26'($urandom_range(0, 3000));
          shots       = 2'($urandom_range(0, 3));
        end
      endcase
      cfg_write(REG_TOLERANCE, 26'(tol));
      cfg_write(REG_TIMEOUT, timeout_val);
      cfg_write(REG_SHOTS, 26'(shots));
      tx_idling = (ph != 2);
      rx_idling = (ph != 5);
      target    = words_sent + 205;
      while (words_sent < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          // well-formed sync run: enter syncing, align, four pulses
          send_word($urandom_range(0, 1) ? FUNC_START : FUNC_MISS,
                    24'($urandom()), tick_span());
          while (st_pulses_left != PULSES_FOR_SYNC)
            send_word(FUNC_PULSE, 24'($urandom()), 24'($urandom()));
          if (st_mode == MODE_WATCH)
            send_word(FUNC_START, 24'($urandom()), 24'($urandom()));
          case ($urandom_range(0, 9))
            0: g0 = 24'd0;
            1, 2: g0 = 24'($urandom());
            3, 4, 5: g0 = 24'($urandom_range(1, 2000));
            // multiples of 100 land exactly on the window edges
            default: g0 = 24'(100 * $urandom_range(1, 160000));
          endcase
          span = int'(cf_tol) + 2;
          pct  = 100 + int'($urandom_range(0, 2 * span)) - span;
          if (pct < 0) pct = 0;
          g1 = 24'((longint'(g0) * pct) / 100);
          if ($urandom_range(0, 3) == 0) g1 = g1 + 24'($urandom_range(0, 2)) - 24'd1;
          base = 24'($urandom());
          send_word(FUNC_PULSE, base, 24'($urandom()));
          send_word(FUNC_PULSE, base + g0, 24'($urandom()));
          send_word(FUNC_PULSE, base + g0 + g1, 24'($urandom()));
          send_word(FUNC_PULSE, 24'($urandom()), 24'($urandom()));
        end else if (pick < 80) begin
          // watching activity: feedback pulses and timer ticks
          repeat ($urandom_range(1, 5)) begin
            if ($urandom_range(0, 1)) send_word(FUNC_PULSE, 24'($urandom()), 24'($urandom()));
            else send_word(FUNC_TICK, 24'($urandom()), tick_span());
          end
        end else begin
          send_word(func_t'($urandom_range(0, 3)), 24'($urandom()), tick_span());
        end
      end
    end
  endtask

  // result sink with random and requested stalls
  initial begin : result_sink
    int wait_left;
    wait_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_req > 0) begin
        wait_left     = sink_hold_req;
        sink_hold_req = 0;
      end else if (wait_left == 0 && rx_idling && $urandom_range(0, 2) == 0) begin
        wait_left = pause_len();
      end
      if (wait_left > 0) begin
        out_ready <= 1'b0;
        wait_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // compare each accepted result word with the oldest expectation
  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        n_errors++;
        $error("result word with nothing expected");
      end else begin
        want = expected_results.pop_front();
        if (out_mode_now !== want.mode_now) begin
          n_errors++;
          $error("mode_now: expected %0d, actual %0d", want.mode_now, out_mode_now);
        end
        if (out_sync_locked !== want.sync_locked) begin
          n_errors++;
          $error("sync_locked: expected %0d, actual %0d", want.sync_locked, out_sync_locked);
        end
        if (out_sync_entered !== want.sync_entered) begin
          n_errors++;
          $error("sync_entered: expected %0d, actual %0d", want.sync_entered, out_sync_entered);
        end
        if (out_camera_trigger !== want.camera_trigger) begin
          n_errors++;
          $error("camera_trigger: expected %0d, actual %0d", want.camera_trigger,
                 out_camera_trigger);
        end
        if (out_trigger_shots !== want.trigger_shots) begin
          n_errors++;
          $error("trigger_shots: expected %0d, actual %0d", want.trigger_shots,
                 out_trigger_shots);
        end
        if (out_feedback_start !== want.feedback_start) begin
          n_errors++;
          $error("feedback_start: expected %0d, actual %0d", want.feedback_start,
                 out_feedback_start);
        end
        if (out_feedback_stop !== want.feedback_stop) begin
          n_errors++;
          $error("feedback_stop: expected %0d, actual %0d", want.feedback_stop,
                 out_feedback_stop);
        end
        if (out_pulse_rearm !== want.pulse_rearm) begin
          n_errors++;
          $error("pulse_rearm: expected %0d, actual %0d", want.pulse_rearm, out_pulse_rearm);
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** ir_beam_sync_break_detector: FAILED **");
      $finish;
    end
  end

  // reset, tests in turn, final report
  initial begin : main_seq
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_index        = REG_TOLERANCE;
    cfg_wdata        = '0;
    in_valid         = 1'b0;
    in_func          = FUNC_PULSE;
    in_pulse_stamp   = '0;
    in_tick_interval = '0;
    tx_idling        = 1'b1;
    rx_idling        = 1'b1;
    sink_hold_req    = 0;
    n_errors         = 0;
    words_sent       = 0;
    quiet_cycles     = 0;
    st_mode          = MODE_WATCH;
    st_pulses_left   = PULSES_FOR_SYNC;
    st_prev_stamp    = '0;
    st_gap0          = '0;
    st_gap1          = '0;
    st_fb_time       = '0;
    cf_tol           = TOL_RESET;
    cf_timeout       = TIMEOUT_RESET;
    cf_shots         = SHOTS_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_power_on_state();
    test_register_extremes();
    test_result_backpressure();
    test_random_traffic();
    wait_results_drained();
    repeat (10) @(posedge clk);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("** ir_beam_sync_break_detector: PASSED **");
    end else begin
      $display("** ir_beam_sync_break_detector: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/ibsb_pkg.sv
rtl/ibsb_tol_check.sv
rtl/ibsb_ctrl.sv
rtl/ir_beam_sync_break_detector.sv
tb/testbench.sv
